/* src/stdcr_pkg.sv */
// Package for the software-triggered DMA channel register block.
// Holds the shared types, codes and constants used by stdcr_lane and the top level.
// No dependencies.
`timescale 1ns / 1ps

package stdcr_pkg;

   // Default sizing handed to the top-level parameters
   localparam int DEF_WINDOW_BYTES = 4096;
   localparam int DEF_CHANNELS     = 16;

   // Input item kinds
   localparam logic [1:0] K_READ  = 2'd0;
   localparam logic [1:0] K_WRITE = 2'd1;
   localparam logic [1:0] K_TICK  = 2'd2;

   // Result item kinds
   localparam logic [1:0] RK_ACCESS = 2'd0;
   localparam logic [1:0] RK_BEAT   = 2'd1;
   localparam logic [1:0] RK_IDLE   = 2'd2;

   // Word slots inside one channel block (byte offset bits 4:2)
   localparam logic [2:0] SLOT_STATUS = 3'd0;
   localparam logic [2:0] SLOT_CLEAR  = 3'd1;
   localparam logic [2:0] SLOT_RSVD   = 3'd2;
   localparam logic [2:0] SLOT_CTRL   = 3'd3;
   localparam logic [2:0] SLOT_TCTRL  = 3'd4;
   localparam logic [2:0] SLOT_COUNT  = 3'd5;
   localparam logic [2:0] SLOT_SRC    = 3'd6;
   localparam logic [2:0] SLOT_DST    = 3'd7;

   // Channel map and exact offsets that carry side effects
   localparam logic [15:0] CH_BASE   = 16'h0040;
   localparam logic [5:0]  OFF_CLEAR = 6'h04;
   localparam logic [5:0]  OFF_CTRL  = 6'h0c;

   // Control and status bits
   localparam int          CTRL_EN_BIT   = 0;
   localparam int          CTRL_SWRQ_BIT = 16;
   localparam logic [31:0] CTRL_CLR_MASK = 32'h0001_0001;
   localparam logic [31:0] DONE_FLAGS    = 32'h0000_001E;

   // Byte count and beat counter width
   localparam int COUNT_W = 17;

   // One input item
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] byte_addr;
      logic [31:0] write_data;
   } req_type;

   // One result item
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] read_data;
      logic [31:0] beat_src;
      logic [31:0] beat_dst;
      logic [3:0]  beat_bytes;
      logic        busy_res;
   } rsp_type;

   // Update command from the top level to one channel lane
   typedef struct packed {
      logic        we;        // plain store into the word at slot
      logic        flag_clr;  // status &= ~wdata
      logic        done;      // set completion flags, drop enable and request
      logic [2:0]  slot;
      logic [31:0] wdata;
   } chan_cmd_type;

   // What one lane shows to the top level
   typedef struct packed {
      logic [31:0] rd_word;
      logic [31:0] ctrl;
      logic [31:0] tctrl;
      logic [31:0] count;
      logic [31:0] src;
      logic [31:0] dst;
   } chan_view_type;

endpackage

/* src/stdcr_lane.sv */
// One DMA channel's register words: status, flag clear, control, transfer control,
// byte count, source and destination. Depends on stdcr_pkg.
`timescale 1ns / 1ps

module stdcr_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  stdcr_pkg::chan_cmd_type cmd,
   output stdcr_pkg::chan_view_type view
);
   import stdcr_pkg::*;

   logic [31:0] status_ff, status_in;
   logic [31:0] clear_ff,  clear_in;
   logic [31:0] ctrl_ff,   ctrl_in;
   logic [31:0] tctrl_ff,  tctrl_in;
   logic [31:0] count_ff,  count_in;
   logic [31:0] src_ff,    src_in;
   logic [31:0] dst_ff,    dst_in;

   // Next values: plain store, then write-one-to-clear, then completion
   always_comb begin
      status_in = status_ff;
      clear_in  = clear_ff;
      ctrl_in   = ctrl_ff;
      tctrl_in  = tctrl_ff;
      count_in  = count_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      if (cmd.we) begin
         unique case (cmd.slot)
            SLOT_STATUS: status_in = cmd.wdata;
            SLOT_CLEAR:  clear_in  = cmd.wdata;
            SLOT_CTRL:   ctrl_in   = cmd.wdata;
            SLOT_TCTRL:  tctrl_in  = cmd.wdata;
            SLOT_COUNT:  count_in  = cmd.wdata;
            SLOT_SRC:    src_in    = cmd.wdata;
            SLOT_DST:    dst_in    = cmd.wdata;
            default:     ;
         endcase
      end
      if (cmd.flag_clr) begin
         status_in = status_in & ~cmd.wdata;
      end
      if (cmd.done) begin
         status_in = status_in | DONE_FLAGS;
         ctrl_in   = ctrl_in & ~CTRL_CLR_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         clear_ff  <= '0;
         ctrl_ff   <= '0;
         tctrl_ff  <= '0;
         count_ff  <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
      end else begin
         status_ff <= status_in;
         clear_ff  <= clear_in;
         ctrl_ff   <= ctrl_in;
         tctrl_ff  <= tctrl_in;
         count_ff  <= count_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
      end
   end

   // Bus read word and the words a trigger snapshots
   always_comb begin
      unique case (cmd.slot)
         SLOT_STATUS: view.rd_word = status_ff;
         SLOT_CLEAR:  view.rd_word = clear_ff;
         SLOT_CTRL:   view.rd_word = ctrl_ff;
         SLOT_TCTRL:  view.rd_word = tctrl_ff;
         SLOT_COUNT:  view.rd_word = count_ff;
         SLOT_SRC:    view.rd_word = src_ff;
         SLOT_DST:    view.rd_word = dst_ff;
         default:     view.rd_word = 32'h0;
      endcase
      view.ctrl  = ctrl_ff;
      view.tctrl = tctrl_ff;
      view.count = count_ff;
      view.src   = src_ff;
      view.dst   = dst_ff;
   end

endmodule

/* src/sw_triggered_dma_channel_regs.sv */
// An accepted item is registered in stage 1, then its result in the result register; one item
// per cycle unless rsp_stall holds a full result register or the clearing pass runs.
// Reset is synchronous, active high. After reset a clearing pass zeroes the word memory,
// one word a cycle, over all (WINDOW_BYTES+3)/4 words (1024 at the default window); req_stall
// stays high during it. Channel registers and transfer state clear at once.
// Top level of the software-triggered DMA channel register block. Depends on stdcr_pkg
// and stdcr_lane.
`timescale 1ns / 1ps

module sw_triggered_dma_channel_regs #(
   parameter int WINDOW_BYTES = stdcr_pkg::DEF_WINDOW_BYTES,
   parameter int CHANNELS     = stdcr_pkg::DEF_CHANNELS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  stdcr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output stdcr_pkg::rsp_type rsp_data
);
   import stdcr_pkg::*;

   localparam int WORDS = (WINDOW_BYTES + 3) / 4;
   localparam int AW    = $clog2(WORDS);

   // Handshake and pipeline registers
   logic    accept, s1_go;
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Clearing pass
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;

   // Plain word memory
   logic [31:0]   mem [WORDS];
   logic [31:0]   mem_rdata_ff;
   logic          fwd_ff, fwd_in;
   logic [31:0]   fwd_data_ff;
   logic          mem_we, mem_we_norm;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic [31:0]   mem_word;

   // Transfer state
   logic               busy_ff, busy_in;
   logic [3:0]         act_ch_ff, act_ch_in;
   logic [COUNT_W-1:0] beat_idx_ff, beat_idx_in;
   logic [COUNT_W-1:0] beat_tot_ff, beat_tot_in;
   logic [31:0]        src_base_ff, src_base_in;
   logic [31:0]        dst_base_ff, dst_base_in;
   logic [7:0]         shape_ff, shape_in;

   // Decode of the staged item
   logic [15:0]   addr;
   logic [31:0]   wdata;
   logic          is_wr, is_tick;
   logic          in_win, ch_ok, lane_word;
   logic [9:0]    ch_full;
   logic [5:0]    off;
   chan_cmd_type  cmd  [CHANNELS];
   chan_view_type view [CHANNELS];
   chan_view_type sel;

   // Trigger and beat logic
   logic               trig, start, inst_done, tick_beat, finish, busy_after;
   logic [31:0]        tc;
   logic [1:0]         sexp, dexp;
   logic [17:0]        round18, sum18, shifted18;
   logic [COUNT_W-1:0] total, idx_next;
   logic [7:0]         new_shape;
   logic [31:0]        src_off, dst_off;

   // Flow control: stage 1 moves on whenever the result register is free or taken
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clr_busy_ff || (s1_valid_ff && !s1_go);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Clearing pass sequencing
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in  = clr_idx_ff + AW'(1);
         clr_busy_in = (clr_idx_ff != AW'(WORDS - 1));
      end
   end

   // Address decode
   always_comb begin
      addr      = s1_ff.byte_addr;
      wdata     = s1_ff.write_data;
      is_wr     = (s1_ff.kind == K_WRITE);
      is_tick   = (s1_ff.kind == K_TICK);
      in_win    = ({1'b0, addr} < 17'(WINDOW_BYTES));
      ch_full   = addr[15:6] - 10'd1;
      off       = addr[5:0];
      ch_ok     = in_win && (addr >= CH_BASE) && (ch_full < 10'(CHANNELS));
      lane_word = ch_ok && !off[5] && (off[4:2] != SLOT_RSVD);
   end

   // Lane addressed by the staged item
   always_comb begin
      sel = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (ch_full == 10'(c)) begin
            sel = view[c];
         end
      end
   end

   // Software trigger: snapshot sizes and beat count from the addressed lane
   always_comb begin
      tc        = sel.tctrl;
      sexp      = tc[5:4];
      dexp      = tc[7:6];
      round18   = (18'd1 << sexp) - 18'd1;
      sum18     = {1'b0, sel.count[COUNT_W-1:0]} + round18;
      shifted18 = sum18 >> sexp;
      total     = (sexp == dexp) ? shifted18[COUNT_W-1:0] : '0;
      new_shape = {tc[11:10], tc[9:8], sexp, |tc[3:2], |tc[1:0]};
      trig      = is_wr && ch_ok && (off == OFF_CTRL) && wdata[CTRL_EN_BIT]
                  && wdata[CTRL_SWRQ_BIT] && !sel.ctrl[CTRL_SWRQ_BIT] && !busy_ff;
      start     = trig && (total != '0);
      inst_done = trig && (total == '0);
   end

   // Copy beat on a tick
   always_comb begin
      tick_beat  = is_tick && busy_ff;
      idx_next   = beat_idx_ff + COUNT_W'(1);
      finish     = tick_beat && (idx_next >= beat_tot_ff);
      src_off    = 32'(beat_idx_ff) << shape_ff[5:4];
      dst_off    = 32'(beat_idx_ff) << shape_ff[7:6];
      busy_after = start ? 1'b1 : (finish ? 1'b0 : busy_ff);
   end

   // Lane commands
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         cmd[c].we       = s1_go && is_wr && lane_word && (ch_full == 10'(c));
         cmd[c].flag_clr = s1_go && is_wr && ch_ok && (off == OFF_CLEAR)
                           && (ch_full == 10'(c));
         cmd[c].done     = s1_go && ((inst_done && (ch_full == 10'(c)))
                           || (finish && (act_ch_ff == 4'(c))));
         cmd[c].slot     = off[4:2];
         cmd[c].wdata    = wdata;
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      stdcr_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd[g]),
         .view  (view[g])
      );
   end

   // Memory write select: clearing pass or a plain store
   always_comb begin
      mem_we_norm = s1_go && is_wr && in_win && !lane_word;
      mem_we      = clr_busy_ff || mem_we_norm;
      mem_waddr   = clr_busy_ff ? clr_idx_ff : addr[AW+1:2];
      mem_wdata   = clr_busy_ff ? 32'h0 : wdata;
      fwd_in      = mem_we_norm && (req_data.byte_addr[AW+1:2] == addr[AW+1:2]);
      mem_word    = fwd_ff ? fwd_data_ff : mem_rdata_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         mem_rdata_ff <= mem[req_data.byte_addr[AW+1:2]];
         fwd_data_ff  <= wdata;
      end
   end

   // Transfer state next values
   always_comb begin
      busy_in     = busy_ff;
      act_ch_in   = act_ch_ff;
      beat_idx_in = beat_idx_ff;
      beat_tot_in = beat_tot_ff;
      src_base_in = src_base_ff;
      dst_base_in = dst_base_ff;
      shape_in    = shape_ff;
      if (s1_go) begin
         if (start) begin
            busy_in     = 1'b1;
            act_ch_in   = ch_full[3:0];
            beat_idx_in = '0;
            beat_tot_in = total;
            src_base_in = sel.src;
            dst_base_in = sel.dst;
            shape_in    = new_shape;
         end else if (tick_beat) begin
            beat_idx_in = idx_next;
            busy_in     = !finish;
         end
      end
   end

   // Result item
   always_comb begin
      rsp_in = '0;
      unique case (s1_ff.kind)
         K_READ: begin
            if (in_win) begin
               rsp_in.read_data = lane_word ? sel.rd_word : mem_word;
            end
         end
         K_WRITE: ;
         K_TICK: begin
            if (busy_ff) begin
               rsp_in.result_kind = RK_BEAT;
               rsp_in.beat_src    = shape_ff[0] ? src_base_ff + src_off : src_base_ff;
               rsp_in.beat_dst    = shape_ff[1] ? dst_base_ff + dst_off : dst_base_ff;
               rsp_in.beat_bytes  = 4'd1 << shape_ff[3:2];
            end else begin
               rsp_in.result_kind = RK_IDLE;
            end
         end
         default: ;
      endcase
      rsp_in.busy_res = busy_after;
   end

   // Registers with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         fwd_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         act_ch_ff    <= '0;
         beat_idx_ff  <= '0;
         beat_tot_ff  <= '0;
         src_base_ff  <= '0;
         dst_base_ff  <= '0;
         shape_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_busy_ff  <= clr_busy_in;
         clr_idx_ff   <= clr_idx_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
         busy_ff      <= busy_in;
         act_ch_ff    <= act_ch_in;
         beat_idx_ff  <= beat_idx_in;
         beat_tot_ff  <= beat_tot_in;
         src_base_ff  <= src_base_in;
         dst_base_ff  <= dst_base_in;
         shape_ff     <= shape_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_data;
      end
      if (s1_go) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A running transfer always has beats left
   a_beats_left: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (beat_idx_ff < beat_tot_ff))
      else $error("beat index reached total while busy");

   // The active channel is a real channel
   a_act_ch: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (32'(act_ch_ff) < CHANNELS))
      else $error("active channel out of range");

   // The last beat ends the transfer
   a_finish: assert property (@(posedge clock) disable iff (reset)
      (s1_go && finish) |=> !busy_ff)
      else $error("transfer still busy after last beat");

   // Reported busy matches the state left behind
   a_busy_res: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> (rsp_ff.busy_res == busy_ff))
      else $error("busy_res disagrees with transfer state");

   // No item enters during the clearing pass
   a_no_accept_clr: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |=> !s1_valid_ff || $past(!clr_busy_ff) || !$past(accept))
      else $error("item accepted during clearing pass");
`endif

endmodule

/* bench/stdcr_checker.sv */
// Response checker for the software-triggered DMA channel register block.
// Watches both channels, mirrors the register file and DMA job state, compares results.
// Depends on stdcr_pkg.
`timescale 1ns / 1ps

module stdcr_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  stdcr_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  stdcr_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 backlog
);
   import stdcr_pkg::*;

   localparam int WINDOW    = DEF_WINDOW_BYTES;
   localparam int NUM_WORDS = (DEF_WINDOW_BYTES + 3) / 4;
   localparam int CH_STRIDE = 64;

   // Mirror of the register window and the running DMA job
   logic [31:0]        csr_words [0:NUM_WORDS-1];
   logic               job_busy;
   logic [3:0]         job_chan;
   logic [COUNT_W-1:0] job_beat;
   logic [COUNT_W-1:0] job_beats;
   logic [31:0]        job_src;
   logic [31:0]        job_dst;
   logic [7:0]         job_shape;   // {dst step, src step, size, dst inc, src inc}

   rsp_type dma_responses [$];

   function automatic int unsigned chan_word(input int unsigned ch);
      return (CH_BASE + ch * CH_STRIDE) >> 2;
   endfunction

   function automatic void clear_state();
      for (int i = 0; i < NUM_WORDS; i++) csr_words[i] = '0;
      job_busy  = 1'b0;
      job_chan  = '0;
      job_beat  = '0;
      job_beats = '0;
      job_src   = '0;
      job_dst   = '0;
      job_shape = '0;
   endfunction

   // Job done: raise completion flags, drop enable and request
   function automatic void close_channel(input int unsigned ch);
      int unsigned w;
      w = chan_word(ch);
      csr_words[w + SLOT_STATUS] = csr_words[w + SLOT_STATUS] | DONE_FLAGS;
      csr_words[w + SLOT_CTRL]   = csr_words[w + SLOT_CTRL] & ~CTRL_CLR_MASK;
   endfunction

   // Snapshot the channel's job; no beats means instant completion
   function automatic void launch_job(input int unsigned ch);
      int unsigned      w;
      logic [31:0]      tc;
      logic [1:0]       sexp;
      logic [1:0]       dexp;
      logic [COUNT_W:0] beats;
      w     = chan_word(ch);
      tc    = csr_words[w + SLOT_TCTRL];
      sexp  = tc[5:4];
      dexp  = tc[7:6];
      beats = '0;
      if (sexp == dexp)
         beats = ({1'b0, csr_words[w + SLOT_COUNT][COUNT_W-1:0]}
                  + ((COUNT_W+1)'(1) << sexp) - (COUNT_W+1)'(1)) >> sexp;
      if (beats == '0) begin
         close_channel(ch);
         return;
      end
      job_busy  = 1'b1;
      job_chan  = ch[3:0];
      job_beat  = '0;
      job_beats = beats[COUNT_W-1:0];
      job_src   = csr_words[w + SLOT_SRC];
      job_dst   = csr_words[w + SLOT_DST];
      job_shape = {tc[11:10], tc[9:8], sexp, |tc[3:2], |tc[1:0]};
   endfunction

   // Bus write with flag-clear and trigger side effects
   function automatic void bus_store(input logic [15:0] a, input logic [31:0] v);
      int unsigned rel;
      int unsigned ch;
      int unsigned off;
      logic [31:0] prior;
      if (a >= WINDOW) return;
      if (a >= CH_BASE) begin
         rel = a - CH_BASE;
         ch  = rel / CH_STRIDE;
         off = rel % CH_STRIDE;
         if (ch < DEF_CHANNELS && off == OFF_CLEAR) begin
            csr_words[chan_word(ch) + SLOT_STATUS] &= ~v;
            csr_words[a >> 2] = v;
            return;
         end
         if (ch < DEF_CHANNELS && off == OFF_CTRL) begin
            prior = csr_words[a >> 2];
            csr_words[a >> 2] = v;
            if (v[CTRL_EN_BIT] && v[CTRL_SWRQ_BIT] && !prior[CTRL_SWRQ_BIT] && !job_busy)
               launch_job(ch);
            return;
         end
      end
      csr_words[a >> 2] = v;
   endfunction

   // One request in, one response out
   function automatic rsp_type dma_regs_apply(input req_type r);
      rsp_type     o;
      logic [31:0] sstep;
      logic [31:0] dstep;
      o = '0;
      case (r.kind)
         K_READ: begin
            if (r.byte_addr < WINDOW) o.read_data = csr_words[r.byte_addr >> 2];
         end
         K_WRITE: begin
            bus_store(r.byte_addr, r.write_data);
         end
         K_TICK: begin
            if (job_busy) begin
               sstep         = 32'd1 << job_shape[5:4];
               dstep         = 32'd1 << job_shape[7:6];
               o.result_kind = RK_BEAT;
               o.beat_src    = job_shape[0] ? job_src + 32'(job_beat) * sstep : job_src;
               o.beat_dst    = job_shape[1] ? job_dst + 32'(job_beat) * dstep : job_dst;
               o.beat_bytes  = 4'd1 << job_shape[3:2];
               job_beat      = job_beat + 1'b1;
               if (job_beat >= job_beats) begin
                  job_busy = 1'b0;
                  close_channel(job_chan);
               end
            end else begin
               o.result_kind = RK_IDLE;
            end
         end
         default: ;   // unused kind: zero response, no state change
      endcase
      o.busy_res = job_busy;
      return o;
   endfunction

   task automatic note_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: rsp %s mismatch, expected %h, actual %h", $time, fname, want, got);
      end
   endtask

   // Compare accepted responses, then fold in the accepted request
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_state();
         dma_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (dma_responses.size() == 0) begin
               fail_count++;
               $display("%0t: rsp with none pending, expected nothing, actual %h",
                        $time, rsp_data);
            end else begin
               want = dma_responses.pop_front();
               note_field("result_kind", want.result_kind, rsp_data.result_kind);
               note_field("read_data", want.read_data, rsp_data.read_data);
               note_field("beat_src", want.beat_src, rsp_data.beat_src);
               note_field("beat_dst", want.beat_dst, rsp_data.beat_dst);
               note_field("beat_bytes", want.beat_bytes, rsp_data.beat_bytes);
               note_field("busy_res", want.busy_res, rsp_data.busy_res);
            end
         end
         if (req_valid && !req_stall) dma_responses.push_back(dma_regs_apply(req_data));
      end
      backlog <= dma_responses.size();
   end

endmodule

/* bench/testbench.sv */
// Top of the bench for the software-triggered DMA channel register block.
// Drives requests and response stalls, reports the verdict from stdcr_checker.
// Depends on stdcr_pkg, stdcr_checker and sw_triggered_dma_channel_regs.
`timescale 1ns / 1ps

module testbench;
   import stdcr_pkg::*;

   localparam int ITEMS     = 400;
   localparam int DIRECTED  = 26;
   localparam int CH_STRIDE = 64;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      mismatches;
   int      outstanding;
   int      sent       = 0;
   bit      req_idling = 1'b1;
   bit      rsp_idling = 1'b1;
   bit      squeeze_go = 1'b0;

   sw_triggered_dma_channel_regs i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   stdcr_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (mismatches),
      .backlog    (outstanding)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] chan_addr(input int ch, input logic [2:0] slot);
      return CH_BASE + 16'(ch * CH_STRIDE) + {11'd0, slot, 2'd0};
   endfunction

   // One request transfer, then maybe an idle burst
   task automatic send(input logic [1:0] k, input logic [15:0] a, input logic [31:0] d);
      req_valid <= 1'b1;
      req_data  <= {k, a, d};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (req_idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Program a channel, trigger it, then tick it along with some side traffic
   task automatic run_job();
      int          ch;
      logic [31:0] tc;
      logic [31:0] nbytes;
      ch     = $urandom_range(0, DEF_CHANNELS - 1);
      tc     = $urandom;
      if ($urandom_range(0, 7) != 0) tc[7:6] = tc[5:4];
      nbytes = ($urandom & 32'hFFFE_0000) | $urandom_range(0, 40);
      send(K_WRITE, chan_addr(ch, SLOT_TCTRL), tc);
      send(K_WRITE, chan_addr(ch, SLOT_COUNT), nbytes);
      send(K_WRITE, chan_addr(ch, SLOT_SRC), $urandom);
      send(K_WRITE, chan_addr(ch, SLOT_DST), $urandom);
      // request must go 0 -> 1 to trigger
      if ($urandom_range(0, 2) == 0) send(K_WRITE, chan_addr(ch, SLOT_CTRL), '0);
      send(K_WRITE, chan_addr(ch, SLOT_CTRL), $urandom | CTRL_CLR_MASK);
      repeat ($urandom_range(1, 45)) begin
         case ($urandom_range(0, 9))
            0: send(K_READ, chan_addr($urandom_range(0, DEF_CHANNELS - 1),
                                      3'($urandom_range(0, 7))), $urandom);
            1: send(K_WRITE, chan_addr(ch, SLOT_CLEAR), $urandom);
            2: send(K_WRITE, chan_addr(ch, 3'($urandom_range(4, 7))), $urandom);
            default: send(K_TICK, 16'($urandom), $urandom);
         endcase
      end
      send(K_READ, chan_addr(ch, SLOT_STATUS), $urandom);
      send(K_READ, chan_addr(ch, SLOT_CTRL), $urandom);
   endtask

   // Random accesses; writes never carry the request bit so no stray jobs start
   task automatic noise_item();
      logic [15:0] a;
      case ($urandom_range(0, 3))
         0: a = 16'($urandom);
         1: a = 16'($urandom_range(0, DEF_WINDOW_BYTES - 1));
         default: a = 16'($urandom_range(CH_BASE, CH_BASE + DEF_CHANNELS * CH_STRIDE - 1));
      endcase
      send(2'($urandom_range(0, 3)), a, $urandom & ~CTRL_CLR_MASK | ($urandom & 32'h1));
   endtask

   // Response side: random stall bursts, plus one long hold-off once the random part starts
   initial begin : rsp_side
      bit squeezed;
      squeezed = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_go && !squeezed) begin
            squeezed = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus and verdict
   initial begin : stim
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // window edges and plain storage
      send(K_READ, chan_addr(0, SLOT_STATUS), '0);
      send(K_WRITE, 16'h0000, 32'hFFFF_FFFF);
      send(K_READ, 16'h0000, '0);
      send(K_WRITE, 16'hFFFC, 32'hA5A5_A5A5);
      send(K_READ, 16'hFFFF, '0);
      send(K_READ, 16'h1000, '0);
      // last channel: sizes differ with a saturated count, completes at once
      send(K_WRITE, chan_addr(15, SLOT_TCTRL), 32'h0000_0090);
      send(K_WRITE, chan_addr(15, SLOT_COUNT), 32'hFFFF_FFFF);
      send(K_WRITE, chan_addr(15, SLOT_CTRL), CTRL_CLR_MASK);
      send(K_READ, chan_addr(15, SLOT_STATUS), '0);
      send(K_READ, chan_addr(15, SLOT_CTRL), '0);
      send(K_WRITE, chan_addr(15, SLOT_CLEAR), 32'h0000_0006);
      send(K_READ, chan_addr(15, SLOT_STATUS), '0);
      // channel 0: halfword beats, source wraps past 32 bits with step 8
      send(K_WRITE, chan_addr(0, SLOT_SRC), 32'hFFFF_FFFC);
      send(K_WRITE, chan_addr(0, SLOT_DST), 32'h1000_0000);
      send(K_WRITE, chan_addr(0, SLOT_COUNT), 32'd10);
      send(K_WRITE, chan_addr(0, SLOT_TCTRL), 32'h0000_035D);
      send(K_WRITE, chan_addr(0, SLOT_CTRL), CTRL_CLR_MASK);
      // trigger on another channel while busy is stored but ignored
      send(K_WRITE, chan_addr(1, SLOT_CTRL), CTRL_CLR_MASK);
      send(2'd3, 16'hFFFF, 32'hFFFF_FFFF);
      repeat (6) send(K_TICK, '0, '0);

      // random part
      squeeze_go = 1'b1;
      while (sent < DIRECTED + ITEMS) begin
         if (sent > DIRECTED + ITEMS - 60) begin
            req_idling = 1'b0;
            rsp_idling = 1'b0;
         end else begin
            req_idling = ($urandom_range(0, 3) != 0);
            rsp_idling = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) noise_item();
         else run_job();
      end
      req_valid <= 1'b0;

      // drain
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("[sw_triggered_dma_channel_regs] OK");
      else
         $display("[sw_triggered_dma_channel_regs] ERROR");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #2_000_000;
      $display("[sw_triggered_dma_channel_regs] ERROR");
      $finish;
   end

endmodule

/* sim.f */
src/stdcr_pkg.sv
src/stdcr_lane.sv
src/sw_triggered_dma_channel_regs.sv
bench/stdcr_checker.sv
bench/testbench.sv
